### hdl/itrd_pkg.sv
// Package for the integer-to-radix-digits converter: field widths, default
// parameters, ASCII constants and the digit-to-character function.
// No dependencies.
package itrd_pkg;

  // Fixed widths of the channel fields
  localparam int VALUE_W = 32;
  localparam int BASE_W  = 7;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  // Defaults for the top-level parameters
  localparam int MAX_DIGITS_DEF = 33;
  localparam int VALUE_BITS_DEF = 32;

  // Quotient bits resolved per divider cycle
  localparam int DIV_BITS_PER_CYCLE = 8;

  // Base register: reset value, radix limits and degenerate-base substitute
  localparam logic [BASE_W-1:0] BASE_RESET = 7'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 7'd36;
  localparam logic [BASE_W-1:0] BASE_MIN   = 7'h5C;  // -36 in two's complement
  localparam logic [BASE_W-1:0] BASE_DEGEN = 7'd2;

  // ASCII offsets: '0' for 0..9, 'A' - 10 for 10..35
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER = 7'd55;
  localparam logic [DIGIT_W-1:0] DECIMAL_TOP  = 6'd10;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {1'b0, d};
    if (d < DECIMAL_TOP) begin
      ascii_of = ASCII_ZERO + ext;
    end else begin
      ascii_of = ASCII_LETTER + ext;
    end
  endfunction

endpackage

### hdl/itrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itrd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/integer_to_radix_digits.sv
// Flow: each request is divided down one digit at a time (D <= MAX_DIGITS),
// each digit from a run of the divider and a finish step; the digits are then
// emitted most significant first while the sink is ready. A new request is
// taken only after the last digit of the previous one has gone out; the
// shared 8-bit-per-cycle divider does the division.
// Reset: idle, base register 2; digit RAM not cleared. Uses itrd_pkg, itrd_ram.
module integer_to_radix_digits #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [itrd_pkg::BASE_W-1:0]  target_base_i,
  // Input request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [itrd_pkg::VALUE_W-1:0] value_i,
  // Digit output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itrd_pkg::CHAR_W-1:0]  digit_char_o,
  output logic [itrd_pkg::DIGIT_W-1:0] digit_value_o,
  output logic                         last_digit_o
);
  import itrd_pkg::*;

  localparam int AW        = $clog2(MAX_DIGITS);
  localparam int CW        = $clog2(MAX_DIGITS + 1);
  localparam int BPC       = DIV_BITS_PER_CYCLE;
  localparam int DIV_STEPS = (VALUE_BITS + BPC - 1) / BPC;
  localparam int PW        = DIV_STEPS * BPC;
  localparam int SW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int IN_BITS   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [BASE_W-1:0]     base_q;
  logic [DIGIT_W-1:0]    bmag_q, bmag_d;
  logic                  bneg_q, bneg_d;
  logic                  qneg_q, qneg_d;
  logic                  comp_q, comp_d;
  logic [SW-1:0]         step_q, step_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         nz_idx_q, nz_idx_d;
  logic                  nz_found_q, nz_found_d;
  logic [PW-1:0]         dq_q, dq_d;
  logic [DIGIT_W:0]      rem_q, rem_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic [DIGIT_W-1:0]    dval_q, dval_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  in_neg;
  logic [DIGIT_W-1:0]    eff_mag;
  logic                  eff_neg;
  logic [PW-1:0]         div_dq;
  logic [DIGIT_W:0]      div_rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] quo_next;
  logic [DIGIT_W-1:0]    rmd;
  logic [DIGIT_W-1:0]    digit;
  logic [CW-1:0]         count_inc;
  logic                  ram_we;
  logic [AW-1:0]         raddr;
  logic [DIGIT_W-1:0]    rdata;
  logic [DIGIT_W-1:0]    emit_d;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digit_char_o  = char_q;
  assign digit_value_o = dval_q;
  assign last_digit_o  = last_q;

  // Take the low bits of the request, zero-extend, split into sign and magnitude
  always_comb begin
    raw = '0;
    raw[IN_BITS-1:0] = value_i[IN_BITS-1:0];
    in_neg = raw[VALUE_BITS-1];
    mag = in_neg ? (~raw + 1'b1) : raw;
  end

  // Clamp the base register and map degenerate bases to 2
  always_comb begin
    logic [BASE_W-1:0] b;
    b = base_q;
    if ($signed(base_q) > $signed(BASE_MAX)) begin
      b = BASE_MAX;
    end else if ($signed(base_q) < $signed(BASE_MIN)) begin
      b = BASE_MIN;
    end else if ($signed(base_q) >= -7'sd1 && $signed(base_q) <= 7'sd1) begin
      b = BASE_DEGEN;
    end
    eff_neg = b[BASE_W-1];
    eff_mag = eff_neg ? DIGIT_W'(~b + 1'b1) : b[DIGIT_W-1:0];
  end

  // Shared divider: resolve BPC quotient bits per cycle by compare-subtract
  always_comb begin
    div_dq  = dq_q;
    div_rem = rem_q;
    for (int i = 0; i < BPC; i++) begin
      div_rem = {div_rem[DIGIT_W-1:0], div_dq[PW-1]};
      div_dq  = {div_dq[PW-2:0], 1'b0};
      if (div_rem >= {1'b0, bmag_q}) begin
        div_rem   = div_rem - {1'b0, bmag_q};
        div_dq[0] = 1'b1;
      end
    end
  end

  // Finish one digit: apply the negabase correction to remainder and quotient
  always_comb begin
    quo      = dq_q[VALUE_BITS-1:0];
    rmd      = rem_q[DIGIT_W-1:0];
    quo_next = quo;
    digit    = rmd;
    qneg_d   = qneg_q;
    if (bneg_q && qneg_q) begin
      qneg_d = 1'b0;
      if (rmd != '0) begin
        digit    = bmag_q - rmd;
        quo_next = quo + 1'b1;
      end
    end else if (bneg_q) begin
      qneg_d = 1'b1;
    end
    count_inc = count_q + 1'b1;
  end

  // Complement digits on the way out when a negative value meets a positive base
  always_comb begin
    emit_d = rdata;
    if (comp_q) begin
      if (!nz_found_q || ptr_q < nz_idx_q) begin
        emit_d = '0;
      end else if (ptr_q == nz_idx_q) begin
        emit_d = bmag_q - rdata;
      end else begin
        emit_d = bmag_q - 1'b1 - rdata;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    bmag_d     = bmag_q;
    bneg_d     = bneg_q;
    comp_d     = comp_q;
    step_d     = step_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    nz_idx_d   = nz_idx_q;
    nz_found_d = nz_found_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    char_d     = char_q;
    dval_d     = dval_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    raddr      = ptr_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          bmag_d     = eff_mag;
          bneg_d     = eff_neg;
          comp_d     = in_neg && !eff_neg;
          dq_d       = '0;
          dq_d[VALUE_BITS-1:0] = mag;
          rem_d      = '0;
          step_d     = '0;
          count_d    = '0;
          nz_found_d = 1'b0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        dq_d  = div_dq;
        rem_d = div_rem;
        if (step_q == SW'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FIN: begin
        ram_we  = 1'b1;
        count_d = count_inc;
        if (!nz_found_q && digit != '0) begin
          nz_found_d = 1'b1;
          nz_idx_d   = count_q[AW-1:0];
        end
        if (quo_next != '0 && count_inc < CW'(MAX_DIGITS)) begin
          dq_d   = '0;
          dq_d[VALUE_BITS-1:0] = quo_next;
          rem_d  = '0;
          step_d = '0;
          state_d = S_DIV;
        end else begin
          ptr_d   = count_q[AW-1:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        char_d  = ascii_of(emit_d);
        dval_d  = emit_d;
        last_d  = (ptr_q == '0);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            raddr   = ptr_q - 1'b1;
            state_d = S_LD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= BASE_RESET;
      count_q    <= '0;
      step_q     <= '0;
      ptr_q      <= '0;
      nz_found_q <= 1'b0;
      nz_idx_q   <= '0;
      comp_q     <= 1'b0;
      qneg_q     <= 1'b0;
      bneg_q     <= 1'b0;
      bmag_q     <= BASE_DEGEN[DIGIT_W-1:0];
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      step_q     <= step_d;
      ptr_q      <= ptr_d;
      nz_found_q <= nz_found_d;
      nz_idx_q   <= nz_idx_d;
      comp_q     <= comp_d;
      bneg_q     <= bneg_d;
      bmag_q     <= bmag_d;
      if (state_q == S_IDLE && in_valid_i) begin
        qneg_q <= eff_neg && in_neg;
      end else if (state_q == S_FIN) begin
        qneg_q <= qneg_d;
      end
      if (cfg_valid_i) begin
        base_q <= target_base_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    char_q <= char_d;
    dval_q <= dval_d;
    last_q <= last_d;
  end

  // Digit store, least significant digit at address 0
  itrd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(digit),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

### hdl/itrd_checker.sv
// Port-level checks for integer_to_radix_digits, attached by bind.
// Depends on itrd_pkg.
module itrd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [itrd_pkg::CHAR_W-1:0]  digit_char_o,
  input logic [itrd_pkg::DIGIT_W-1:0] digit_value_o,
  input logic                         last_digit_o
);
  import itrd_pkg::*;

  // Hold off new requests while digits are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request accepted while digits pending");

  // Drop ready once a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("ready after request accepted");

  // Return to idle right after the final digit goes out
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_digit_o) |=> (in_ready_o && !out_valid_o))
    else $error("not idle after final digit");

  // Character and digit value agree
  a_char_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o == ascii_of(digit_value_o)))
    else $error("digit character mismatch");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .digit_value_o(digit_value_o),
  .last_digit_o (last_digit_o)
);

### sim/tb_integer_to_radix_digits.sv
// Testbench for integer_to_radix_digits: drives value requests and base
// writes, predicts each digit string and checks every emitted digit.
// Depends on itrd_pkg and the integer_to_radix_digits RTL.
`timescale 1ns / 100ps

module tb_integer_to_radix_digits;
  import itrd_pkg::*;

  localparam int DIGITS_KEPT    = 33;
  localparam int RADIX_LIMIT    = 36;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEMS_PER_BASE = 10;
  localparam int BASES_PER_MODE = 7;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;
  } digit_t;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SENDER,
    GAP_RECEIVER,
    GAP_BOTH
  } gap_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [BASE_W-1:0]  target_base_i = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic [DIGIT_W-1:0] digit_value_o;
  logic               last_digit_o;

  // Predictor state and bookkeeping
  digit_t            digits_due[$];
  logic [BASE_W-1:0] base_reg_model = BASE_RESET;
  gap_mode_e         gap_mode       = GAP_NONE;
  int                fail_count     = 0;
  bit                hold_req       = 1'b0;
  bit                hold_seen      = 1'b0;
  int                hold_left      = 0;

  integer_to_radix_digits i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .target_base_i (target_base_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_char_o  (digit_char_o),
    .digit_value_o (digit_value_o),
    .last_digit_o  (last_digit_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Map the raw base register to the radix actually used
  function automatic int radix_in_use(logic [BASE_W-1:0] reg_val);
    int radix;
    radix = int'($signed(reg_val));
    if (radix > RADIX_LIMIT) radix = RADIX_LIMIT;
    if (radix < -RADIX_LIMIT) radix = -RADIX_LIMIT;
    if (radix >= -1 && radix <= 1) radix = 2;
    return radix;
  endfunction

  // Convert one value and queue its digits, most significant first
  function automatic void convert_value(logic [VALUE_W-1:0] value);
    longint             num;
    longint             rem;
    int                 radix;
    int                 count;
    int                 carry;
    int                 d;
    bit                 complement;
    logic [DIGIT_W-1:0] digits[DIGITS_KEPT];
    digit_t             dig;
    radix      = radix_in_use(base_reg_model);
    num        = longint'($signed(value));
    complement = (radix > 0) && (num < 0);
    if (complement) num = -num;
    count = 0;
    do begin
      rem = num % radix;
      num = num / radix;
      if (rem < 0) begin
        rem += (radix < 0) ? -radix : radix;
        num += 1;
      end
      digits[count] = DIGIT_W'(rem);
      count++;
    end while (num != 0 && count < DIGITS_KEPT);
    // Radix complement of the magnitude, carry out dropped
    if (complement) begin
      carry = 1;
      for (int k = 0; k < count; k++) begin
        d = radix - 1 - int'(digits[k]) + carry;
        if (d >= radix) begin
          d -= radix;
          carry = 1;
        end else begin
          carry = 0;
        end
        digits[k] = DIGIT_W'(d);
      end
    end
    for (int k = count - 1; k >= 0; k--) begin
      dig.digit_value = digits[k];
      if (digits[k] < DECIMAL_TOP) begin
        dig.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
      end else begin
        dig.digit_char = ASCII_LETTER + CHAR_W'(digits[k]);
      end
      dig.last_digit = (k == 0);
      digits_due.push_back(dig);
    end
  endfunction

  function automatic int sender_gap_pct();
    case (gap_mode)
      GAP_SENDER: return 50;
      GAP_BOTH:   return 21;
      default:    return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (gap_mode)
      GAP_RECEIVER: return 50;
      GAP_BOTH:     return 21;
      default:      return 0;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 200);
      2:       v = 32'h7FFF_FFFF - $urandom_range(0, 50);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Send one value request; valid stays high for a following request
  task automatic send_value(logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < sender_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    convert_value(value);
  endtask

  // Drop valid and hold until every queued digit has come out
  task automatic wait_all_digits();
    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(logic [BASE_W-1:0] base);
    wait_all_digits();
    cfg_valid_i   <= 1'b1;
    target_base_i <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    base_reg_model  = base;
  endtask

  // Count down a long sink hold-off when one is asked for
  always @(posedge clk_i) begin : hold_off
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each emitted digit and drive the sink ready
  always @(posedge clk_i) begin : check_digits
    digit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digits_due.size() == 0) begin
        $error("digit with no request pending: char %0d value %0d last %0d",
               digit_char_o, digit_value_o, last_digit_o);
        fail_count++;
      end else begin
        want = digits_due.pop_front();
        if (digit_char_o !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char, digit_char_o);
          fail_count++;
        end
        if (digit_value_o !== want.digit_value) begin
          $error("digit_value: expected %0d, got %0d", want.digit_value, digit_value_o);
          fail_count++;
        end
        if (last_digit_o !== want.last_digit) begin
          $error("last_digit: expected %0d, got %0d", want.last_digit, last_digit_o);
          fail_count++;
        end
      end
    end
    // Hold the sink off while a hold-off is running
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // Reset base of two, then zero and small signed values
  task automatic test_reset_base();
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd5);
  endtask

  // Decimal with the extremes of the value field
  task automatic test_decimal_extremes();
    write_base(7'd10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0001);
    send_value(32'h8000_0000);
    send_value(32'd9);
    send_value(-32'sd10);
  endtask

  // Largest radix magnitudes, positive and negative
  task automatic test_radix_limits();
    write_base(7'd36);
    send_value(32'd35);
    send_value(-32'sd35);
    send_value(32'h7FFF_FFFF);
    write_base(BASE_MIN);
    send_value(32'd35);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
  endtask

  // Base minus two: longest digit strings, the digit limit is hit
  task automatic test_negabase_two();
    write_base(7'h7E);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
  endtask

  // Register values beyond the radix range saturate
  task automatic test_base_saturation();
    write_base(7'h3F);
    send_value(32'd36);
    write_base(7'h40);
    send_value(32'd36);
    write_base(7'd37);
    send_value(-32'sd37);
    write_base(7'h5B);
    send_value(32'd1000);
  endtask

  // Bases minus one, zero and one act as two
  task automatic test_degenerate_base();
    write_base(7'd0);
    send_value(32'd6);
    write_base(7'd1);
    send_value(-32'sd6);
    write_base(7'h7F);
    send_value(32'h5555_5555);
  endtask

  // Random values over many bases in every idling mode
  task automatic test_random_traffic();
    logic [BASE_W-1:0] base;
    for (int m = 0; m < 4; m++) begin
      gap_mode = gap_mode_e'(m);
      for (int p = 0; p < BASES_PER_MODE; p++) begin
        case (p)
          0:       base = BASE_MAX;
          1:       base = BASE_MIN;
          2:       base = 7'd2;
          3:       base = 7'h7E;
          default: base = BASE_W'($urandom_range(0, 127));
        endcase
        write_base(base);
        for (int i = 0; i < ITEMS_PER_BASE; i++) send_value(random_value());
      end
    end
  endtask

  // Stall the sink long enough to back up the input, then pause source and sink at random
  task automatic test_backpressure();
    gap_mode = GAP_NONE;
    write_base(BASE_W'($urandom_range(0, 127)));
    hold_req = ~hold_req;
    for (int i = 0; i < 12; i++) send_value(random_value());
    wait_all_digits();
    gap_mode = GAP_BOTH;
    for (int i = 0; i < 12; i++) send_value(random_value());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_base();
    test_decimal_extremes();
    test_radix_limits();
    test_negabase_two();
    test_base_saturation();
    test_degenerate_base();
    test_random_traffic();
    test_backpressure();
    wait_all_digits();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
hdl/itrd_pkg.sv
hdl/itrd_ram.sv
hdl/integer_to_radix_digits.sv
hdl/itrd_checker.sv
sim/tb_integer_to_radix_digits.sv
